### rtl/core/lmsw_pkg.sv
`default_nettype none

package lmsw_pkg;

  localparam int PANEL_WIDTH     = 32;
  localparam int COL_W           = $clog2(PANEL_WIDTH);
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int SECS_PER_MIN    = 60;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STEP   = 2'd1,
    FUNC_REDRAW = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIRROR  = 3'd0,
    CFG_FLIP    = 3'd1,
    CFG_SCREEN  = 3'd2,
    CFG_JUSTIFY = 3'd3,
    CFG_SCROLL  = 3'd4,
    CFG_BAR     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    JUSTIFY_LEFT   = 2'd0,
    JUSTIFY_CENTER = 2'd1,
    JUSTIFY_RIGHT  = 2'd2
  } justify_e;

  typedef enum logic [1:0] {
    SCROLL_WHEN_WIDE = 2'd0,
    SCROLL_ALWAYS    = 2'd1,
    SCROLL_NEVER     = 2'd2
  } scroll_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT,
    ST_DRAIN
  } state_e;

  // One window position on its way from the store read to the output stage.
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic             last;
    logic [COL_W-1:0] pos;
  } pix_ctl_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lmsw_pixel.sv
`default_nettype none

module lmsw_pixel (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lmsw_pkg::pix_ctl_t       ctl_i,
  input  wire logic [7:0]               rd_data_i,
  input  wire logic                     flip_i,
  input  wire logic                     mirror_i,
  input  wire logic                     bar_en_i,
  input  wire logic [5:0]               seconds_i,
  output logic                          strobe_o,
  output logic [lmsw_pkg::COL_W-1:0]    panel_column_o,
  output logic [7:0]                    pixel_bits_o,
  output logic                          frame_end_o
);
  import lmsw_pkg::*;

  localparam int BAR_W = $clog2(63 * PANEL_WIDTH + 1);

  logic [BAR_W-1:0] bar_lhs, bar_rhs;
  logic             bar_on;
  logic [7:0]       bits;
  logic [COL_W-1:0] phys;

  logic             strobe_q;
  logic [COL_W-1:0] col_q;
  logic [7:0]       bits_q;
  logic             end_q;

  // Position p is under the bar when (p + 1) * 60 <= seconds * width.
  always_comb begin
    bar_lhs = BAR_W'(seconds_i) * BAR_W'(PANEL_WIDTH);
    bar_rhs = (BAR_W'(ctl_i.pos) + BAR_W'(1)) * BAR_W'(SECS_PER_MIN);
    bar_on  = bar_en_i && (bar_rhs <= bar_lhs);
    bits    = ctl_i.hit ? rd_data_i : 8'h00;
    if (bar_on) begin
      bits[7] = 1'b1;
    end
    if (flip_i) begin
      bits = reverse8(bits);
    end
    phys = flip_i ? (COL_W'(PANEL_WIDTH - 1) - ctl_i.pos) : ctl_i.pos;
    if (mirror_i) begin
      phys = COL_W'(PANEL_WIDTH - 1) - phys;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      col_q  <= phys;
      bits_q <= bits;
      end_q  <= ctl_i.last;
    end
  end

  assign strobe_o       = strobe_q;
  assign panel_column_o = col_q;
  assign pixel_bits_o   = bits_q;
  assign frame_end_o    = end_q;

endmodule

`default_nettype wire

### rtl/core/led_matrix_scroll_window.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+---------------------------
// command   | func_i column_bits_i first_column_i final_column_i | start high while busy low
//           | seconds_now_i                                      |
// result    | panel_column_o pixel_bits_o frame_end_o            | result_valid_o, one cycle
// config    | cfg_we_i cfg_idx_i cfg_data_i                      | cfg_we_i, no wait
//
// A plain load writes one word to the store. A final load then passes ST_DECIDE for the scroll
// decision. A frame makes one store read per window column through the shared offset
// adder, then goes through one read and one output register stage. Results leave one per
// cycle and cannot be held off.
// Reset clears the control state; the column store is not cleared.

`default_nettype none

module led_matrix_scroll_window #(
  parameter int MAX_COLUMNS = lmsw_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     func_i,
  input  wire logic [7:0]                     column_bits_i,
  input  wire logic                           first_column_i,
  input  wire logic                           final_column_i,
  input  wire logic [5:0]                     seconds_now_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [lmsw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [lmsw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                result_valid_o,
  output logic [lmsw_pkg::COL_W-1:0]          panel_column_o,
  output logic [7:0]                          pixel_bits_o,
  output logic                                frame_end_o
);
  import lmsw_pkg::*;

  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int AW    = $clog2(MAX_COLUMNS);
  localparam int OFF_W = CNT_W + 2;
  localparam logic signed [OFF_W-1:0] NEG_PANEL = OFF_W'(-PANEL_WIDTH);

  // config
  logic       mirror_q, flip_q, screen_q, bar_q;
  logic [1:0] justify_q, scroll_pref_q;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         lp_q, lp_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [OFF_W-1:0]  offset_q, offset_d;
  logic                     scroll_q, scroll_d;
  logic [COL_W-1:0]         pos_q, pos_d;
  logic [5:0]               seconds_q;
  pix_ctl_t                 ctl_q, ctl_d;

  logic                     accept;
  logic signed [OFF_W-1:0]  add_b, add_sum;
  logic                     sum_above, sum_inside;
  logic [CNT_W-1:0]         base;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic                     rd_en;
  logic signed [OFF_W-1:0]  spare;
  logic                     too_wide;

  logic [7:0] store_mem [MAX_COLUMNS];
  logic [7:0] rd_data_q;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Shared adder: window offset plus position while emitting, plus one on a step.
  always_comb begin
    add_b      = (state_q == ST_EMIT) ? $signed(OFF_W'(pos_q)) : $signed(OFF_W'(1));
    add_sum    = offset_q + add_b;
    sum_above  = !add_sum[OFF_W-1] && (add_sum[OFF_W-2:0] > {1'b0, count_q});
    sum_inside = !add_sum[OFF_W-1] && (add_sum[OFF_W-2:0] < {1'b0, count_q});
  end

  always_comb begin
    spare    = $signed(OFF_W'(PANEL_WIDTH)) - $signed(OFF_W'(count_q));
    too_wide = count_q > CNT_W'(PANEL_WIDTH);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_LOAD:   if (final_column_i) state_d = ST_DECIDE;
            FUNC_STEP:   if (scroll_q && screen_q) state_d = ST_EMIT;
            FUNC_REDRAW: if (screen_q) state_d = ST_EMIT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_DECIDE: state_d = screen_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (pos_q == COL_W'(PANEL_WIDTH - 1)) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    lp_d     = lp_q;
    count_d  = count_q;
    offset_d = offset_q;
    scroll_d = scroll_q;
    pos_d    = pos_q;
    ctl_d    = '0;
    base     = first_column_i ? '0 : lp_q;
    we       = 1'b0;
    waddr    = base[AW-1:0];
    rd_en    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_LOAD: begin
              // drop the word once the store is full
              if (base < CNT_W'(MAX_COLUMNS)) begin
                we   = 1'b1;
                lp_d = base + CNT_W'(1);
              end else begin
                lp_d = base;
              end
              if (final_column_i) begin
                count_d = lp_d;
              end
            end
            FUNC_STEP: begin
              if (scroll_q) begin
                offset_d = sum_above ? NEG_PANEL : add_sum;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DECIDE: begin
        priority case (scroll_pref_q)
          SCROLL_ALWAYS: scroll_d = 1'b1;
          SCROLL_NEVER:  scroll_d = 1'b0;
          default:       scroll_d = too_wide;
        endcase
        if (scroll_d) begin
          offset_d = NEG_PANEL;
        end else if (count_q >= CNT_W'(PANEL_WIDTH)) begin
          offset_d = '0;
        end else begin
          priority case (justify_q)
            JUSTIFY_CENTER: offset_d = -(spare >>> 1);
            JUSTIFY_RIGHT:  offset_d = -spare;
            default:        offset_d = '0;
          endcase
        end
      end
      ST_EMIT: begin
        rd_en     = sum_inside;
        ctl_d.vld = 1'b1;
        ctl_d.hit = sum_inside;
        ctl_d.pos = pos_q;
        if (pos_q == COL_W'(PANEL_WIDTH - 1)) begin
          ctl_d.last = 1'b1;
          pos_d      = '0;
        end else begin
          pos_d = pos_q + COL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      lp_q     <= '0;
      count_q  <= '0;
      offset_q <= '0;
      scroll_q <= 1'b0;
      pos_q    <= '0;
      ctl_q    <= '0;
    end else begin
      state_q  <= state_d;
      lp_q     <= lp_d;
      count_q  <= count_d;
      offset_q <= offset_d;
      scroll_q <= scroll_d;
      pos_q    <= pos_d;
      ctl_q    <= ctl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q      <= 1'b0;
      flip_q        <= 1'b0;
      screen_q      <= 1'b1;
      justify_q     <= JUSTIFY_LEFT;
      scroll_pref_q <= SCROLL_WHEN_WIDE;
      bar_q         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIRROR:  mirror_q      <= cfg_data_i[0];
        CFG_FLIP:    flip_q        <= cfg_data_i[0];
        CFG_SCREEN:  screen_q      <= cfg_data_i[0];
        CFG_JUSTIFY: justify_q     <= cfg_data_i;
        CFG_SCROLL:  scroll_pref_q <= cfg_data_i;
        CFG_BAR:     bar_q         <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seconds_q <= seconds_now_i;
    end
  end

  // column store
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_mem[waddr] <= column_bits_i;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[add_sum[AW-1:0]];
    end
  end

  lmsw_pixel u_pixel (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl_q),
    .rd_data_i      (rd_data_q),
    .flip_i         (flip_q),
    .mirror_i       (mirror_q),
    .bar_en_i       (bar_q),
    .seconds_i      (seconds_q),
    .strobe_o       (result_valid_o),
    .panel_column_o (panel_column_o),
    .pixel_bits_o   (pixel_bits_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

`default_nettype wire

### tb/lmsw_frame_checker.sv
`timescale 1ns / 100ps

module lmsw_frame_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic                            busy_i,
  input  wire logic [1:0]                      func_i,
  input  wire logic [7:0]                      column_bits_i,
  input  wire logic                            first_column_i,
  input  wire logic                            final_column_i,
  input  wire logic [5:0]                      seconds_now_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [lmsw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lmsw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            result_valid_i,
  input  wire logic [lmsw_pkg::COL_W-1:0]      panel_column_i,
  input  wire logic [7:0]                      pixel_bits_i,
  input  wire logic                            frame_end_i,
  output int                                   err_count_o,
  output int                                   pending_o,
  output int                                   words_o
);
  import lmsw_pkg::*;

  localparam int STORE_DEPTH = MAX_COLUMNS_DEF;
  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [7:0]       bits;
    logic             last;
  } column_word_t;

  logic [7:0]   store [STORE_DEPTH];
  int           msg_len = 0;
  int           wr_ptr = 0;
  int           offset = 0;
  bit           scrolling = 1'b0;
  bit           mirror = 1'b0;
  bit           flip = 1'b0;
  bit           screen = 1'b1;
  bit           bar = 1'b0;
  logic [1:0]   justify = JUSTIFY_LEFT;
  logic [1:0]   scroll_mode = SCROLL_WHEN_WIDE;
  column_word_t expected_columns [$];
  int           errors = 0;
  int           words = 0;

  assign err_count_o = errors;
  assign words_o     = words;

  task automatic report_mismatch(input string what);
    if (errors < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    errors++;
  endtask

  function automatic int justified_offset();
    int spare;
    spare = PANEL_WIDTH - msg_len;
    if (msg_len >= PANEL_WIDTH) return 0;
    if (justify == JUSTIFY_CENTER) return -(spare / 2);
    if (justify == JUSTIFY_RIGHT) return -spare;
    return 0;
  endfunction

  // Queue the PANEL_WIDTH words of the current window, unless the screen is off.
  task automatic render_window(input logic [5:0] secs);
    int           bar_len;
    int           src;
    int           phys;
    logic [7:0]   v;
    column_word_t w;
    if (!screen) return;
    bar_len = bar ? (int'(secs) * PANEL_WIDTH) / SECS_PER_MIN : 0;
    for (int p = 0; p < PANEL_WIDTH; p++) begin
      src = offset + p;
      v = (src >= 0 && src < msg_len) ? store[src] : 8'h00;
      if (p < bar_len) v[7] = 1'b1;
      phys = flip ? PANEL_WIDTH - 1 - p : p;
      if (mirror) phys = PANEL_WIDTH - 1 - phys;
      w.col = phys[COL_W-1:0];
      for (int b = 0; b < 8; b++) begin
        w.bits[b] = flip ? v[7-b] : v[b];
      end
      w.last = (p == PANEL_WIDTH - 1);
      expected_columns.push_back(w);
    end
  endtask

  task automatic take_command();
    case (func_e'(func_i))
      FUNC_LOAD: begin
        if (first_column_i) wr_ptr = 0;
        // drop the column once the store is full
        if (wr_ptr < STORE_DEPTH) begin
          store[wr_ptr] = column_bits_i;
          wr_ptr++;
        end
        if (final_column_i) begin
          msg_len = wr_ptr;
          if (scroll_mode == SCROLL_ALWAYS) scrolling = 1'b1;
          else if (scroll_mode == SCROLL_NEVER) scrolling = 1'b0;
          else scrolling = (msg_len > PANEL_WIDTH);
          offset = scrolling ? -PANEL_WIDTH : justified_offset();
          render_window(seconds_now_i);
        end
      end
      FUNC_STEP: begin
        if (scrolling) begin
          offset++;
          if (offset > msg_len) offset = -PANEL_WIDTH;
          render_window(seconds_now_i);
        end
      end
      FUNC_REDRAW: render_window(seconds_now_i);
      default: ;
    endcase
  endtask

  task automatic write_register();
    case (cfg_idx_e'(cfg_idx_i))
      CFG_MIRROR:  mirror = cfg_data_i[0];
      CFG_FLIP:    flip = cfg_data_i[0];
      CFG_SCREEN:  screen = cfg_data_i[0];
      CFG_JUSTIFY: justify = cfg_data_i;
      CFG_SCROLL:  scroll_mode = cfg_data_i;
      CFG_BAR:     bar = cfg_data_i[0];
      default: ;
    endcase
  endtask

  task automatic check_word();
    column_word_t want;
    if (expected_columns.size() == 0) begin
      report_mismatch($sformatf("unexpected word col %0d bits %02h end %0b",
                                panel_column_i, pixel_bits_i, frame_end_i));
      return;
    end
    want = expected_columns.pop_front();
    words++;
    if (panel_column_i !== want.col) begin
      report_mismatch($sformatf("panel_column got %0d want %0d", panel_column_i, want.col));
    end
    if (pixel_bits_i !== want.bits) begin
      report_mismatch($sformatf("pixel_bits got %02h want %02h at col %0d",
                                pixel_bits_i, want.bits, want.col));
    end
    if (frame_end_i !== want.last) begin
      report_mismatch($sformatf("frame_end got %0b want %0b at col %0d",
                                frame_end_i, want.last, want.col));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len = 0;
      wr_ptr = 0;
      offset = 0;
      scrolling = 1'b0;
      mirror = 1'b0;
      flip = 1'b0;
      screen = 1'b1;
      justify = JUSTIFY_LEFT;
      scroll_mode = SCROLL_WHEN_WIDE;
      bar = 1'b0;
      expected_columns.delete();
      pending_o <= 0;
    end else begin
      if (result_valid_i) check_word();
      if (start_i && !busy_i) take_command();
      if (cfg_we_i) write_register();
      pending_o <= expected_columns.size();
    end
  end

endmodule

### tb/led_matrix_scroll_window_tb.sv
`timescale 1ns / 100ps

module led_matrix_scroll_window_tb;
  import lmsw_pkg::*;

  localparam logic [1:0] FUNC_IGNORED   = 2'd3;
  localparam logic [1:0] JUSTIFY_SPARE  = 2'd3;
  localparam logic [1:0] SCROLL_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT    = 600000;
  localparam int         DRAIN_LIMIT    = 2000;
  localparam int         SETTLE_CYCLES  = PANEL_WIDTH + 8;
  localparam int         LONG_MESSAGE   = MAX_COLUMNS_DEF + 6;
  localparam int         RANDOM_ITEMS   = 400;
  localparam int         PHASE_ITEMS    = 50;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            func_i = FUNC_LOAD;
  logic [7:0]            column_bits_i = 8'h00;
  logic                  first_column_i = 1'b0;
  logic                  final_column_i = 1'b0;
  logic [5:0]            seconds_now_i = 6'd0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_MIRROR;
  logic [CFG_DATA_W-1:0] cfg_data_i = 2'd0;
  logic                  result_valid_o;
  logic [COL_W-1:0]      panel_column_o;
  logic [7:0]            pixel_bits_o;
  logic                  frame_end_o;

  int errors;
  int pending;
  int words;
  int cycles = 0;
  int commands = 0;
  int settings = 0;
  bit gaps_on = 1'b1;

  led_matrix_scroll_window u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .column_bits_i  (column_bits_i),
    .first_column_i (first_column_i),
    .final_column_i (final_column_i),
    .seconds_now_i  (seconds_now_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .panel_column_o (panel_column_o),
    .pixel_bits_o   (pixel_bits_o),
    .frame_end_o    (frame_end_o)
  );

  lmsw_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func_i),
    .column_bits_i  (column_bits_i),
    .first_column_i (first_column_i),
    .final_column_i (final_column_i),
    .seconds_now_i  (seconds_now_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_i (result_valid_o),
    .panel_column_i (panel_column_o),
    .pixel_bits_i   (pixel_bits_o),
    .frame_end_i    (frame_end_o),
    .err_count_o    (errors),
    .pending_o      (pending),
    .words_o        (words)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cycle limit hit with %0d words outstanding", pending);
      $display("led_matrix_scroll_window_tb: FAIL");
      $finish;
    end
  end

  // Enter and leave at a falling edge; start drops again after acceptance.
  task automatic issue(input logic [1:0] f, input logic [7:0] bits, input logic first,
                       input logic fin, input logic [5:0] secs);
    if (gaps_on && $urandom_range(99) < 6) begin
      repeat ($urandom_range(1, PANEL_WIDTH + 4)) @(negedge clk_i);
    end
    func_i = f;
    column_bits_i = bits;
    first_column_i = first;
    final_column_i = fin;
    seconds_now_i = secs;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start = 1'b0;
    if (f != FUNC_IGNORED) commands++;
  endtask

  // Hold until every expected word is out and the block has settled.
  task automatic wait_quiet();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [1:0] val);
    cfg_idx_i = idx;
    cfg_data_i = val;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input logic [1:0] m, input logic [1:0] fl, input logic [1:0] scr,
                           input logic [1:0] j, input logic [1:0] sc, input logic [1:0] b);
    wait_quiet();
    write_reg(CFG_MIRROR, m);
    write_reg(CFG_FLIP, fl);
    write_reg(CFG_SCREEN, scr);
    write_reg(CFG_JUSTIFY, j);
    write_reg(CFG_SCROLL, sc);
    write_reg(CFG_BAR, b);
    settings++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      issue(FUNC_LOAD, 8'($urandom_range(255)), i == 0, i == len - 1,
            6'($urandom_range(63)));
    end
  endtask

  initial begin
    int         random_base;
    int         next_phase;
    int         drain;
    int         len;
    logic [1:0] scr;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // nothing loaded yet: step is ignored, redraw shows a blank panel
    issue(FUNC_STEP, 8'h00, 1'b0, 1'b0, 6'd0);
    issue(FUNC_REDRAW, 8'hFF, 1'b1, 1'b1, 6'd63);
    issue(FUNC_IGNORED, 8'hFF, 1'b1, 1'b1, 6'd63);
    issue(FUNC_LOAD, 8'hFF, 1'b1, 1'b0, 6'd0);
    issue(FUNC_LOAD, 8'h00, 1'b0, 1'b0, 6'd0);
    issue(FUNC_LOAD, 8'hA5, 1'b0, 1'b1, 6'd59);
    issue(FUNC_REDRAW, 8'h00, 1'b0, 1'b0, 6'd0);

    configure(2'd1, 2'd0, 2'd1, JUSTIFY_CENTER, SCROLL_WHEN_WIDE, 2'd1);
    issue(FUNC_LOAD, 8'h81, 1'b1, 1'b1, 6'd30);
    issue(FUNC_REDRAW, 8'h00, 1'b0, 1'b0, 6'd63);
    issue(FUNC_REDRAW, 8'h00, 1'b0, 1'b0, 6'd1);

    configure(2'd0, 2'd1, 2'd1, JUSTIFY_RIGHT, SCROLL_NEVER, 2'd1);
    send_message(5);
    issue(FUNC_STEP, 8'h00, 1'b0, 1'b0, 6'd45);

    configure(2'd1, 2'd1, 2'd1, JUSTIFY_SPARE, SCROLL_ALWAYS, 2'd0);
    issue(FUNC_LOAD, 8'h3C, 1'b1, 1'b1, 6'd10);
    issue(FUNC_STEP, 8'h00, 1'b0, 1'b0, 6'd20);
    issue(FUNC_STEP, 8'h00, 1'b0, 1'b0, 6'd21);

    // screen off: state moves on, nothing comes out
    configure(2'd1, 2'd1, 2'd0, JUSTIFY_SPARE, SCROLL_ALWAYS, 2'd1);
    issue(FUNC_STEP, 8'h00, 1'b0, 1'b0, 6'd5);
    issue(FUNC_REDRAW, 8'h00, 1'b0, 1'b0, 6'd5);
    issue(FUNC_LOAD, 8'hC3, 1'b1, 1'b1, 6'd5);

    configure(2'd0, 2'd0, 2'd1, JUSTIFY_LEFT, SCROLL_SPARE, 2'd0);
    issue(FUNC_REDRAW, 8'h00, 1'b0, 1'b0, 6'd60);
    issue(FUNC_STEP, 8'h00, 1'b0, 1'b0, 6'd61);

    // overflow the store, then end the message again with the pointer saturated
    configure(2'd0, 2'd0, 2'd1, JUSTIFY_LEFT, SCROLL_WHEN_WIDE, 2'd1);
    send_message(LONG_MESSAGE);
    repeat (3) issue(FUNC_STEP, 8'h00, 1'b0, 1'b0, 6'($urandom_range(63)));
    issue(FUNC_LOAD, 8'h5A, 1'b0, 1'b1, 6'd45);
    configure(2'd0, 2'd0, 2'd1, JUSTIFY_RIGHT, SCROLL_NEVER, 2'd0);
    issue(FUNC_LOAD, 8'hE7, 1'b0, 1'b1, 6'd0);
    issue(FUNC_REDRAW, 8'h00, 1'b0, 1'b0, 6'd0);

    random_base = commands;
    next_phase = commands;
    while (commands - random_base < RANDOM_ITEMS) begin
      if (commands >= next_phase) begin
        if (next_phase == random_base) begin
          configure(2'd3, 2'd3, 2'd3, JUSTIFY_SPARE, SCROLL_SPARE, 2'd3);
        end else if (next_phase == random_base + PHASE_ITEMS) begin
          configure(2'd0, 2'd0, 2'd1, JUSTIFY_LEFT, SCROLL_WHEN_WIDE, 2'd0);
        end else begin
          scr = ($urandom_range(5) == 0) ? 2'd2 : ($urandom_range(1) ? 2'd3 : 2'd1);
          configure(2'($urandom_range(3)), 2'($urandom_range(3)), scr,
                    2'($urandom_range(3)), 2'($urandom_range(3)), 2'($urandom_range(3)));
        end
        next_phase = commands + PHASE_ITEMS;
      end
      gaps_on = !((commands - random_base) inside {[150:250]});
      if ($urandom_range(99) < 70) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 34);
        send_message(len);
        repeat ($urandom_range(0, 45)) begin
          issue(($urandom_range(4) == 0) ? FUNC_REDRAW : FUNC_STEP, 8'($urandom_range(255)),
                1'($urandom_range(1)), 1'($urandom_range(1)), 6'($urandom_range(63)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          issue(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 6'($urandom_range(63)));
        end
      end
      if ($urandom_range(19) == 0) wait_quiet();
    end

    start = 1'b0;
    drain = 0;
    while ((pending != 0 || busy) && drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("%0d commands over %0d register settings, %0d panel words checked",
             commands, settings, words);
    $display("covered store overflow, scroll wrap, justification, flip, mirror and the bar");
    if (errors == 0 && pending == 0) begin
      $display("led_matrix_scroll_window_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d expected words never came", errors, pending);
      $display("led_matrix_scroll_window_tb: FAIL");
    end
    $finish;
  end

endmodule
